### sv/cca_pkg.sv
package cca_pkg;

  localparam int CLASS_BITS   = 4;
  localparam int VALUE_BITS   = 16;
  localparam int TOL_BITS     = 15;
  localparam int ERR_BITS     = 40;
  localparam int REPORT_BITS  = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  // wide enough for value +/- tolerance and differences of two values
  localparam int WIDE_BITS = VALUE_BITS + 2;
  localparam int ABS_BITS  = VALUE_BITS + 1;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_REGRESSION = 2'd0;
  localparam mode_t MODE_MULTI      = 2'd1;
  localparam mode_t MODE_SINGLE     = 2'd2;

  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_EVAL_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEPARATOR = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE = 2'd2;

  localparam logic signed [VALUE_BITS-1:0] SEP_RESET = 16'sd2048;
  localparam logic [TOL_BITS-1:0]          TOL_RESET = 15'd410;

  // one and minus two in Q3.12
  localparam logic signed [WIDE_BITS-1:0]  Q_ONE     = 18'sd4096;
  localparam logic signed [VALUE_BITS-1:0] START_MAX = -16'sd8192;

endpackage

### sv/classification_confusion_accumulator.sv
// Per-class confusion counters for a stream of classifier output elements, one element per
// beat. Every accepted beat gives exactly one result beat: the updated true/false
// positive/negative counts and absolute error sum of its class, plus the running well and
// missed sample counts. A beat may be accepted on every clock unless a stalled result holds
// the input register; each beat passes through the input register and then the result
// register. The rate is set by the per-class counters, which live in flip-flops and are
// read, updated and written back in the same cycle, so consecutive beats of the same
// class need no forwarding. A clear command zeroes all counters at once; there is no
// clearing pass after reset. Counters saturate. Configuration writes are always taken
// (cfg_ready is tied high) and must only be made while no beat is in flight.
module classification_confusion_accumulator
  import cca_pkg::*;
#(
  parameter int NUM_CLASSES = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [CLASS_BITS-1:0]          in_class_index,
  input  logic signed [VALUE_BITS-1:0]   in_predicted,
  input  logic signed [VALUE_BITS-1:0]   in_desired,
  input  logic [CLASS_BITS-1:0]          in_target_class,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [CLASS_BITS-1:0]          out_class,
  output logic [REPORT_BITS-1:0]         out_true_pos,
  output logic [REPORT_BITS-1:0]         out_true_neg,
  output logic [REPORT_BITS-1:0]         out_false_pos,
  output logic [REPORT_BITS-1:0]         out_false_neg,
  output logic [ERR_BITS-1:0]            out_error_sum,
  output logic                           out_sample_done,
  output logic                           out_sample_correct,
  output logic [REPORT_BITS-1:0]         out_well_count,
  output logic [REPORT_BITS-1:0]         out_miss_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]       cfg_data
);

  localparam int IDX_BITS = (NUM_CLASSES > 2) ? $clog2(NUM_CLASSES) : 1;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [ERR_BITS-1:0]   err_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    sat_inc = (c == '1) ? c : c + 1'b1;
  endfunction

  // configuration
  mode_t                         mode_r;
  logic signed [VALUE_BITS-1:0]  sep_r;
  logic [TOL_BITS-1:0]           tol_r;

  // input register
  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_cmd_r;
  logic [CLASS_BITS-1:0]         s1_cls_r;
  logic signed [VALUE_BITS-1:0]  s1_p_r, s1_d_r;
  logic [CLASS_BITS-1:0]         s1_tgt_r;
  logic                          s1_last_r;

  // per-class counters
  cnt_t tp_r [NUM_CLASSES];
  cnt_t tn_r [NUM_CLASSES];
  cnt_t fp_r [NUM_CLASSES];
  cnt_t fn_r [NUM_CLASSES];
  err_t err_r [NUM_CLASSES];

  // sample tracking
  cnt_t                          good_r, good_nxt;
  cnt_t                          bad_r, bad_nxt;
  logic                          failed_r, failed_nxt;
  logic signed [VALUE_BITS-1:0]  max_r, max_nxt;
  logic [CLASS_BITS-1:0]         amax_r, amax_nxt;
  logic                          amax_ok_r, amax_ok_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [CLASS_BITS-1:0]         out_class_r;
  logic [REPORT_BITS-1:0]        out_tp_r, out_tn_r, out_fp_r, out_fn_r;
  err_t                          out_err_r;
  logic                          out_done_r, out_correct_r;
  logic [REPORT_BITS-1:0]        out_well_r, out_miss_r;

  logic                          adv, take, fire, clear, ok;
  logic [IDX_BITS-1:0]           idx;
  logic signed [WIDE_BITS-1:0]   p_x, d_x, tol_x, diff;
  logic [ABS_BITS-1:0]           abs_err;
  logic [ERR_BITS:0]             err_sum;
  logic                          p_hi, d_hi;
  logic                          inc_tp, inc_tn, inc_fp, inc_fn;
  logic                          correct;
  cnt_t                          tp_new, tn_new, fp_new, fn_new;
  err_t                          err_new;

  // handshake: result register parts the two sides
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign take     = in_valid && !in_stall;
  assign fire     = s1_valid_r && adv;
  assign cfg_ready = 1'b1;

  assign s1_valid_nxt  = take ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  assign clear = (s1_cmd_r == CMD_CLEAR);
  assign ok    = int'(s1_cls_r) < NUM_CLASSES;
  assign idx   = IDX_BITS'(s1_cls_r);

  always_comb begin
    p_x   = WIDE_BITS'(s1_p_r);
    d_x   = WIDE_BITS'(s1_d_r);
    tol_x = WIDE_BITS'(tol_r);
    p_hi  = s1_p_r > sep_r;
    d_hi  = s1_d_r > sep_r;

    inc_tp = 1'b0;
    inc_tn = 1'b0;
    inc_fp = 1'b0;
    inc_fn = 1'b0;
    failed_nxt  = failed_r;
    max_nxt     = max_r;
    amax_nxt    = amax_r;
    amax_ok_nxt = amax_ok_r;
    diff        = d_x - p_x;

    if (mode_r == MODE_REGRESSION) begin
      if (p_x > d_x + tol_x) begin
        inc_fp = 1'b1;
        failed_nxt = 1'b1;
      end else if (p_x < d_x - tol_x) begin
        inc_fn = 1'b1;
        failed_nxt = 1'b1;
      end else begin
        inc_tn = 1'b1;
      end
    end else if (mode_r == MODE_MULTI) begin
      inc_tp = p_hi && d_hi;
      inc_tn = !p_hi && !d_hi;
      inc_fp = p_hi && !d_hi;
      inc_fn = !p_hi && d_hi;
      if (p_hi != d_hi) begin
        failed_nxt = 1'b1;
      end
    end else begin
      // single label: target class aims at one, the others at zero
      if (s1_cls_r == s1_tgt_r) begin
        diff   = Q_ONE - p_x;
        inc_tp = p_hi;
        inc_fn = !p_hi;
      end else begin
        diff   = p_x;
        inc_fp = p_hi;
        inc_tn = !p_hi;
      end
      // strictly greater, so the first maximum wins
      if (max_r < s1_p_r) begin
        max_nxt     = s1_p_r;
        amax_nxt    = s1_cls_r;
        amax_ok_nxt = 1'b1;
      end
    end

    abs_err = diff[WIDE_BITS-1] ? ABS_BITS'(-diff) : ABS_BITS'(diff);

    tp_new  = inc_tp ? sat_inc(tp_r[idx]) : tp_r[idx];
    tn_new  = inc_tn ? sat_inc(tn_r[idx]) : tn_r[idx];
    fp_new  = inc_fp ? sat_inc(fp_r[idx]) : fp_r[idx];
    fn_new  = inc_fn ? sat_inc(fn_r[idx]) : fn_r[idx];
    err_sum = {1'b0, err_r[idx]} + (ERR_BITS + 1)'(abs_err);
    err_new = err_sum[ERR_BITS] ? '1 : err_sum[ERR_BITS-1:0];

    if (mode_r == MODE_REGRESSION || mode_r == MODE_MULTI) begin
      correct = !failed_nxt;
    end else begin
      correct = amax_ok_nxt && (amax_nxt == s1_tgt_r);
    end

    good_nxt = good_r;
    bad_nxt  = bad_r;
    if (s1_last_r) begin
      if (correct) begin
        good_nxt = sat_inc(good_r);
      end else begin
        bad_nxt = sat_inc(bad_r);
      end
      failed_nxt  = 1'b0;
      max_nxt     = START_MAX;
      amax_nxt    = '0;
      amax_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SINGLE;
      sep_r  <= SEP_RESET;
      tol_r  <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EVAL_MODE: mode_r <= cfg_data[1:0];
        CFG_SEPARATOR: sep_r  <= cfg_data[VALUE_BITS-1:0];
        CFG_TOLERANCE: tol_r  <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd_r  <= in_cmd;
      s1_cls_r  <= in_class_index;
      s1_p_r    <= in_predicted;
      s1_d_r    <= in_desired;
      s1_tgt_r  <= in_target_class;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && clear)) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        tp_r[i]  <= '0;
        tn_r[i]  <= '0;
        fp_r[i]  <= '0;
        fn_r[i]  <= '0;
        err_r[i] <= '0;
      end
      good_r    <= '0;
      bad_r     <= '0;
      failed_r  <= 1'b0;
      max_r     <= START_MAX;
      amax_r    <= '0;
      amax_ok_r <= 1'b0;
    end else if (fire) begin
      if (ok) begin
        tp_r[idx]  <= tp_new;
        tn_r[idx]  <= tn_new;
        fp_r[idx]  <= fp_new;
        fn_r[idx]  <= fn_new;
        err_r[idx] <= err_new;
      end
      good_r    <= good_nxt;
      bad_r     <= bad_nxt;
      failed_r  <= failed_nxt;
      max_r     <= max_nxt;
      amax_r    <= amax_nxt;
      amax_ok_r <= amax_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_class_r <= s1_cls_r;
      if (clear) begin
        out_tp_r      <= '0;
        out_tn_r      <= '0;
        out_fp_r      <= '0;
        out_fn_r      <= '0;
        out_err_r     <= '0;
        out_done_r    <= 1'b0;
        out_correct_r <= 1'b0;
        out_well_r    <= '0;
        out_miss_r    <= '0;
      end else begin
        out_tp_r      <= ok ? REPORT_BITS'(tp_new) : '0;
        out_tn_r      <= ok ? REPORT_BITS'(tn_new) : '0;
        out_fp_r      <= ok ? REPORT_BITS'(fp_new) : '0;
        out_fn_r      <= ok ? REPORT_BITS'(fn_new) : '0;
        out_err_r     <= ok ? err_new : '0;
        out_done_r    <= s1_last_r;
        out_correct_r <= s1_last_r && correct;
        out_well_r    <= REPORT_BITS'(good_nxt);
        out_miss_r    <= REPORT_BITS'(bad_nxt);
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_class          = out_class_r;
  assign out_true_pos       = out_tp_r;
  assign out_true_neg       = out_tn_r;
  assign out_false_pos      = out_fp_r;
  assign out_false_neg      = out_fn_r;
  assign out_error_sum      = out_err_r;
  assign out_sample_done    = out_done_r;
  assign out_sample_correct = out_correct_r;
  assign out_well_count     = out_well_r;
  assign out_miss_count     = out_miss_r;

endmodule

### sv/cca_checker.sv
module cca_checker
  import cca_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_sample_done,
  input logic                   out_sample_correct,
  input logic [REPORT_BITS-1:0] out_well_count,
  input logic [REPORT_BITS-1:0] out_miss_count,
  input logic [ERR_BITS-1:0]    out_error_sum
);

  // nothing comes out of reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

  // a closed good sample is counted
  a_well_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_done && out_sample_correct |-> out_well_count != '0)
    else $error("good sample not counted");

  // a closed bad sample is counted
  a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_done && !out_sample_correct |-> out_miss_count != '0)
    else $error("missed sample not counted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_error_sum))
    else $error("stalled result changed");

endmodule

bind classification_confusion_accumulator cca_checker u_cca_checker (.*);

### sim/classification_confusion_accumulator_test.sv
`timescale 1ns / 100ps

module classification_confusion_accumulator_test
  import cca_pkg::*;
;

  localparam mode_t MODE_SINGLE_ALT = 2'd3;
  localparam longint unsigned ERR_LIMIT = (64'd1 << ERR_BITS) - 1;
  localparam int SQUEEZE_CYCLES = 80;

  typedef struct packed {
    logic [CLASS_BITS-1:0]  cls;
    logic [REPORT_BITS-1:0] tp;
    logic [REPORT_BITS-1:0] tn;
    logic [REPORT_BITS-1:0] fp;
    logic [REPORT_BITS-1:0] fn;
    logic [ERR_BITS-1:0]    err;
    logic                   done;
    logic                   correct;
    logic [REPORT_BITS-1:0] well;
    logic [REPORT_BITS-1:0] miss;
  } class_report_t;

  class confusion_tracker;
    logic [REPORT_BITS-1:0] tp[16], tn[16], fp[16], fn[16];
    longint unsigned err_sum[16];
    logic [REPORT_BITS-1:0] well, miss;
    bit failed;
    int top_val;
    logic [CLASS_BITS-1:0] top_cls;
    bit top_valid;
    mode_t mode;
    int sep;
    int tol;
    class_report_t expected_reports[$];
    int mismatches;

    function new();
      clear_counts();
      mode = MODE_SINGLE;
      sep = int'(SEP_RESET);
      tol = int'(TOL_RESET);
      mismatches = 0;
    endfunction

    function void clear_counts();
      for (int i = 0; i < 16; i++) begin
        tp[i] = '0; tn[i] = '0; fp[i] = '0; fn[i] = '0; err_sum[i] = 0;
      end
      well = '0;
      miss = '0;
      failed = 1'b0;
      top_val = int'(START_MAX);
      top_cls = '0;
      top_valid = 1'b0;
    endfunction

    function logic [REPORT_BITS-1:0] bump(logic [REPORT_BITS-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function longint unsigned grow(longint unsigned s, int diff);
      longint unsigned a;
      a = (diff < 0) ? longint'(-diff) : longint'(diff);
      return (a >= ERR_LIMIT - s) ? ERR_LIMIT : s + a;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_EVAL_MODE: mode = data[1:0];
        CFG_SEPARATOR: sep = int'($signed(data));
        CFG_TOLERANCE: tol = int'(data[TOL_BITS-1:0]);
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_element(logic cmd, logic [CLASS_BITS-1:0] cls, int p, int d,
                               logic [CLASS_BITS-1:0] tgt, logic last);
      class_report_t r;
      bit hi, dh, correct;
      r = '0;
      r.cls = cls;
      if (cmd == CMD_CLEAR) begin
        clear_counts();
        expected_reports.push_back(r);
        return;
      end
      if (mode >= MODE_SINGLE) begin
        hi = p > sep;
        if (top_val < p) begin
          top_val = p;
          top_cls = cls;
          top_valid = 1'b1;
        end
        if (cls == tgt) begin
          err_sum[cls] = grow(err_sum[cls], int'(Q_ONE) - p);
          if (hi) tp[cls] = bump(tp[cls]);
          else fn[cls] = bump(fn[cls]);
        end else begin
          err_sum[cls] = grow(err_sum[cls], p);
          if (hi) fp[cls] = bump(fp[cls]);
          else tn[cls] = bump(tn[cls]);
        end
      end else if (mode == MODE_REGRESSION) begin
        if (p > d + tol) begin
          failed = 1'b1;
          fp[cls] = bump(fp[cls]);
        end else if (p < d - tol) begin
          failed = 1'b1;
          fn[cls] = bump(fn[cls]);
        end else begin
          tn[cls] = bump(tn[cls]);
        end
        err_sum[cls] = grow(err_sum[cls], d - p);
      end else begin
        hi = p > sep;
        dh = d > sep;
        if (hi && dh) tp[cls] = bump(tp[cls]);
        else if (!hi && !dh) tn[cls] = bump(tn[cls]);
        else if (hi) begin
          failed = 1'b1;
          fp[cls] = bump(fp[cls]);
        end else begin
          failed = 1'b1;
          fn[cls] = bump(fn[cls]);
        end
        err_sum[cls] = grow(err_sum[cls], d - p);
      end
      if (last) begin
        // verdict follows the mode in force at the closing element
        correct = (mode >= MODE_SINGLE) ? (top_valid && top_cls == tgt) : !failed;
        if (correct) well = bump(well);
        else miss = bump(miss);
        r.done = 1'b1;
        r.correct = correct;
        failed = 1'b0;
        top_val = int'(START_MAX);
        top_cls = '0;
        top_valid = 1'b0;
      end
      r.tp = tp[cls];
      r.tn = tn[cls];
      r.fp = fp[cls];
      r.fn = fn[cls];
      r.err = err_sum[cls][ERR_BITS-1:0];
      r.well = well;
      r.miss = miss;
      expected_reports.push_back(r);
    endfunction

    function void check_field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s mismatch: expected %0d, got %0d", name, e, a);
        mismatches++;
      end
    endfunction

    function void check_report(class_report_t act);
      class_report_t e;
      if (expected_reports.size() == 0) begin
        $error("result beat with nothing expected: class %0d", act.cls);
        mismatches++;
        return;
      end
      e = expected_reports.pop_front();
      check_field("out_class", e.cls, act.cls);
      check_field("out_true_pos", e.tp, act.tp);
      check_field("out_true_neg", e.tn, act.tn);
      check_field("out_false_pos", e.fp, act.fp);
      check_field("out_false_neg", e.fn, act.fn);
      check_field("out_error_sum", e.err, act.err);
      check_field("out_sample_done", e.done, act.done);
      check_field("out_sample_correct", e.correct, act.correct);
      check_field("out_well_count", e.well, act.well);
      check_field("out_miss_count", e.miss, act.miss);
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_cmd = 1'b0;
  logic [CLASS_BITS-1:0]        in_class_index = '0;
  logic signed [VALUE_BITS-1:0] in_predicted = '0;
  logic signed [VALUE_BITS-1:0] in_desired = '0;
  logic [CLASS_BITS-1:0]        in_target_class = '0;
  logic                         in_last = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [CLASS_BITS-1:0]        out_class;
  logic [REPORT_BITS-1:0]       out_true_pos;
  logic [REPORT_BITS-1:0]       out_true_neg;
  logic [REPORT_BITS-1:0]       out_false_pos;
  logic [REPORT_BITS-1:0]       out_false_neg;
  logic [ERR_BITS-1:0]          out_error_sum;
  logic                         out_sample_done;
  logic                         out_sample_correct;
  logic [REPORT_BITS-1:0]       out_well_count;
  logic [REPORT_BITS-1:0]       out_miss_count;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_BITS-1:0]      cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]     cfg_data = '0;

  confusion_tracker tracker = new();
  bit squeeze_req = 1'b0;
  int burst_left = 4;
  mode_t cur_mode = MODE_SINGLE;
  int cur_sep = 2048;

  classification_confusion_accumulator DUT (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        tracker.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        tracker.note_element(in_cmd, in_class_index, in_predicted, in_desired,
                             in_target_class, in_last);
      if (out_valid && !out_stall)
        tracker.check_report('{out_class, out_true_pos, out_true_neg, out_false_pos,
                               out_false_neg, out_error_sum, out_sample_done,
                               out_sample_correct, out_well_count, out_miss_count});
    end
  end

  // receiver: changing stall patterns, plus a long hold when asked for
  initial begin : stall_gen
    int style;
    int span;
    @(posedge rst_n);
    forever begin
      if (squeeze_req) begin
        for (int held = 0; held < SQUEEZE_CYCLES; held++) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
        squeeze_req = 1'b0;
      end else begin
        style = $urandom_range(0, 3);
        span = $urandom_range(5, 60);
        repeat (span) begin
          @(posedge clk);
          case (style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
          if (squeeze_req) break;
        end
      end
    end
  end

  task automatic send_element(input bit cmd, input int cls, input int p, input int d,
                              input int tgt, input bit last);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_class_index <= CLASS_BITS'(cls);
    in_predicted <= VALUE_BITS'(p);
    in_desired <= VALUE_BITS'(d);
    in_target_class <= CLASS_BITS'(tgt);
    in_last <= last;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0 && !squeeze_req) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_idle();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper bits of mode and tolerance get random values
  task automatic set_config(input mode_t mode, input int sep, input int tol);
    wait_idle();
    write_reg(CFG_EVAL_MODE, {14'($urandom), mode});
    write_reg(CFG_SEPARATOR, CFG_DATA_BITS'(sep));
    write_reg(CFG_TOLERANCE, {1'($urandom), TOL_BITS'(tol)});
    cur_mode = mode;
    cur_sep = sep;
  endtask

  function automatic int pick_value(int centre);
    int v;
    case ($urandom_range(0, 7))
      0: v = -32768;
      1: v = 32767;
      2, 3: v = centre + $urandom_range(0, 1200) - 600;
      4: v = centre;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic run_samples(input int count);
    int sent;
    int k;
    int tgt;
    int cls;
    int p;
    int d;
    bit noise;
    bit last;
    bit cmd;
    sent = 0;
    while (sent < count) begin
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(2, 6);
      tgt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, k - 1);
      noise = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < k; i++) begin
        cls = noise ? $urandom_range(0, 15) : i;
        last = (i == k - 1);
        if (noise && $urandom_range(0, 2) == 0) last = ~last;
        cmd = ($urandom_range(0, 199) == 0);
        d = (cur_mode == MODE_MULTI) ? pick_value(cur_sep) : pick_value(0);
        p = (cur_mode == MODE_REGRESSION) ? pick_value(d) : pick_value(cur_sep);
        send_element(cmd, cls, p, d, tgt, last);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int sep;
    int tol;
    int waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-label with reset settings: ties, start value, no maximum at all
    send_element(1'b0, 0, -32768, 32767, 2, 1'b0);
    send_element(1'b0, 1, 4096, -32768, 2, 1'b0);
    send_element(1'b0, 2, 4096, 0, 2, 1'b0);
    send_element(1'b0, 3, 2048, 0, 2, 1'b1);
    send_element(1'b0, 0, -8192, 0, 0, 1'b0);
    send_element(1'b0, 1, -32768, 0, 0, 1'b1);
    send_element(1'b0, 14, 100, 0, 15, 1'b0);
    send_element(1'b0, 15, 32767, 0, 15, 1'b1);
    send_element(CMD_CLEAR, 7, 0, 0, 0, 1'b0);

    // regression, zero band then widest band
    set_config(MODE_REGRESSION, -32768, 0);
    send_element(1'b0, 0, -32768, -32768, 0, 1'b0);
    send_element(1'b0, 1, 32767, -32768, 0, 1'b0);
    send_element(1'b0, 2, -32768, 32767, 0, 1'b1);
    send_element(1'b0, 0, 100, 100, 0, 1'b1);
    set_config(MODE_REGRESSION, 0, 32767);
    send_element(1'b0, 3, 32767, 0, 0, 1'b1);

    // multi-label at both separator extremes
    set_config(MODE_MULTI, 32767, 410);
    send_element(1'b0, 0, 32767, 32767, 0, 1'b1);
    set_config(MODE_MULTI, -32768, 410);
    send_element(1'b0, 0, -32768, -32767, 0, 1'b0);
    send_element(1'b0, 1, 0, 0, 0, 1'b1);

    // mode switched half way through a sample
    set_config(MODE_MULTI, 0, 410);
    send_element(1'b0, 0, 5, -5, 0, 1'b0);
    set_config(MODE_REGRESSION, 0, 410);
    send_element(1'b0, 1, 0, 0, 0, 1'b1);
    set_config(MODE_SINGLE_ALT, 2048, 410);
    send_element(1'b0, 0, 1000, 0, 1, 1'b0);
    set_config(MODE_MULTI, 2048, 410);
    send_element(1'b0, 1, 3000, 0, 1, 1'b1);
    set_config(MODE_SINGLE_ALT, 0, 410);
    send_element(1'b0, 0, -1, 0, 1, 1'b0);
    send_element(1'b0, 1, 4000, 0, 1, 1'b1);
    send_element(CMD_CLEAR, 9, 0, 0, 0, 1'b1);

    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 4))
        0: sep = -32768;
        1: sep = 32767;
        2: sep = 0;
        default: sep = int'($urandom_range(0, 65535)) - 32768;
      endcase
      case ($urandom_range(0, 3))
        0: tol = 0;
        1: tol = 32767;
        2: tol = $urandom_range(0, 2000);
        default: tol = $urandom_range(0, 32767);
      endcase
      set_config(mode_t'($urandom_range(0, 3)), sep, tol);
      if (phase == 1) squeeze_req = 1'b1;
      run_samples(100);
    end

    if (in_valid) in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (tracker.pending() != 0 && waited < 20000);
    repeat (20) @(posedge clk);
    if (tracker.pending() != 0)
      $error("%0d expected results never arrived", tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
